>>> src/indexed_min_heap_assert.svh
// Assertion macros used by the checker of the indexed min-heap.
`ifndef INDEXED_MIN_HEAP_ASSERT_SVH
`define INDEXED_MIN_HEAP_ASSERT_SVH

// Checks that a property holds at every clock edge outside reset.
`define IMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds at a clock edge outside reset.
`define IMH_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/imh_pkg.sv
// Shared types and constants of the indexed min-heap.
package imh_pkg;

  localparam int NumItems = 1024;
  localparam int IdxW     = $clog2(NumItems);
  localparam int CntW     = IdxW + 1;
  localparam int KeyW     = 32;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [KeyW-1:0] key_t;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_LOOKUP,
    CMD_DECIDE,
    CMD_RM,
    CMD_POP,
    CMD_UP_RD,
    CMD_UP_MOVE,
    CMD_DN_RD,
    CMD_DN_MOVE,
    CMD_PLACE,
    CMD_TOP_RD,
    CMD_RESULT
  } cmd_t;

  // One heap slot.
  typedef struct packed {
    idx_t item;
    key_t key;
  } slot_t;

  // One position map entry.
  typedef struct packed {
    logic present;
    idx_t slot;
  } pos_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic present;
    logic cnt_zero;
    logic clr_last;
    logic rm_same;
    logic rm_down;
    logic up_move;
    logic left_ok;
    logic dn_move;
    logic out_busy;
  } stat_t;

endpackage

>>> src/imh_ctrl.sv
// Sequencer that steps the heap datapath through each request.
module imh_ctrl
  import imh_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_DECIDE, ST_RM, ST_POP, ST_UP_RD, ST_UP_CMP,
    ST_DN_RD, ST_DN_CMP, ST_PLACE, ST_TOP_RD, ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   try_down_r, try_down_nxt;

  // Next state and command.
  always_comb begin
    state_nxt    = state_r;
    try_down_nxt = try_down_r;
    cmd          = CMD_NONE;
    unique case (state_r)
      ST_CLEAR: begin
        cmd = CMD_CLEAR;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd       = CMD_LOOKUP;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd = CMD_DECIDE;
        unique case (stat.op)
          OP_UPDATE: begin
            try_down_nxt = stat.present;
            state_nxt    = ST_UP_RD;
          end
          OP_REMOVE: state_nxt = stat.present ? ST_RM : ST_TOP_RD;
          OP_POP:    state_nxt = stat.cnt_zero ? ST_TOP_RD : ST_POP;
          default:   state_nxt = ST_TOP_RD;
        endcase
      end
      ST_RM: begin
        cmd          = CMD_RM;
        try_down_nxt = 1'b0;
        priority if (stat.rm_same) state_nxt = ST_TOP_RD;
        else if (stat.rm_down)     state_nxt = ST_DN_RD;
        else                       state_nxt = ST_UP_RD;
      end
      ST_POP: begin
        cmd       = CMD_POP;
        state_nxt = stat.cnt_zero ? ST_TOP_RD : ST_DN_RD;
      end
      ST_UP_RD: begin
        cmd       = CMD_UP_RD;
        state_nxt = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        priority if (stat.up_move) begin
          cmd          = CMD_UP_MOVE;
          try_down_nxt = 1'b0;
          state_nxt    = ST_UP_RD;
        end else if (try_down_r) begin
          state_nxt = ST_DN_RD;
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_DN_RD: begin
        if (stat.left_ok) begin
          cmd       = CMD_DN_RD;
          state_nxt = ST_DN_CMP;
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_DN_CMP: begin
        if (stat.dn_move) begin
          cmd       = CMD_DN_MOVE;
          state_nxt = ST_DN_RD;
        end else begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd       = CMD_PLACE;
        state_nxt = ST_TOP_RD;
      end
      ST_TOP_RD: begin
        cmd       = CMD_TOP_RD;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!stat.out_busy) begin
          cmd       = CMD_RESULT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      try_down_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      try_down_r <= try_down_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

>>> src/imh_datapath.sv
// Heap memories, position map, working registers and result register.
module imh_datapath
  import imh_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  cmd,
  output stat_t stat,
  input  logic  [1:0] in_operation,
  input  idx_t  in_item_index,
  input  key_t  in_new_key,
  input  logic  out_stall,
  output logic  out_valid,
  output logic  out_was_present,
  output key_t  out_popped_key,
  output idx_t  out_popped_index,
  output logic  out_top_valid,
  output key_t  out_top_key,
  output idx_t  out_top_index,
  output cnt_t  out_entry_count,
  output logic  out_status
);

  slot_t heap_mem [NumItems];
  pos_t  pm_mem   [NumItems];

  // Control registers.
  cnt_t cnt_r;
  idx_t clr_addr_r;
  logic out_valid_r;

  // Working registers.
  op_t   op_r;
  idx_t  item_r;
  key_t  key_r;
  idx_t  s_r;
  slot_t hold_r;
  key_t  pkey_r;
  idx_t  pidx_r;
  logic  status_r;
  slot_t rd_a_q, rd_b_q;
  pos_t  pm_q;

  // Result register.
  logic  o_was_r, o_top_valid_r, o_status_r;
  key_t  o_pkey_r, o_top_key_r;
  idx_t  o_pidx_r, o_top_idx_r;
  cnt_t  o_cnt_r;

  // Memory access controls.
  logic  heap_we, rd_en, pm_we, pm_re;
  idx_t  heap_waddr, addr_a, addr_b, pm_waddr;
  slot_t heap_wdata;
  pos_t  pm_wdata;

  // Address helpers for sift steps.
  cnt_t  left, right, last;
  idx_t  parent, pick_slot;
  logic  use_b;
  slot_t pick;

  assign left      = {s_r, 1'b1};
  assign right     = left + cnt_t'(1);
  assign last      = cnt_r - cnt_t'(1);
  assign parent    = (s_r - idx_t'(1)) >> 1;
  assign use_b     = (right < cnt_r) && (rd_b_q.key < rd_a_q.key);
  assign pick      = use_b ? rd_b_q : rd_a_q;
  assign pick_slot = use_b ? right[IdxW-1:0] : left[IdxW-1:0];

  // Status toward the controller.
  always_comb begin
    stat.op       = op_r;
    stat.present  = pm_q.present;
    stat.cnt_zero = (cnt_r == '0);
    stat.clr_last = (clr_addr_r == '1);
    stat.rm_same  = ({1'b0, s_r} == cnt_r);
    stat.rm_down  = (rd_a_q.key < rd_b_q.key);
    stat.up_move  = (s_r != '0) && (hold_r.key < rd_a_q.key);
    stat.left_ok  = (left < cnt_r);
    stat.dn_move  = (pick.key < hold_r.key);
    stat.out_busy = out_valid_r && out_stall;
  end

  // Memory addresses and write data per command.
  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = s_r;
    heap_wdata = hold_r;
    rd_en      = 1'b0;
    addr_a     = '0;
    addr_b     = '0;
    pm_we      = 1'b0;
    pm_re      = 1'b0;
    pm_waddr   = item_r;
    pm_wdata   = '0;
    unique case (cmd)
      CMD_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_addr_r;
      end
      CMD_LOOKUP: pm_re = 1'b1;
      CMD_DECIDE: begin
        if (op_r == OP_REMOVE && pm_q.present) begin
          pm_we  = 1'b1;
          rd_en  = 1'b1;
          addr_a = pm_q.slot;
          addr_b = last[IdxW-1:0];
        end else if (op_r == OP_POP && cnt_r != '0) begin
          rd_en  = 1'b1;
          addr_b = last[IdxW-1:0];
        end
      end
      CMD_POP: begin
        pm_we    = 1'b1;
        pm_waddr = rd_a_q.item;
      end
      CMD_UP_RD: begin
        rd_en  = 1'b1;
        addr_a = parent;
      end
      CMD_UP_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = rd_a_q;
        pm_we      = 1'b1;
        pm_waddr   = rd_a_q.item;
        pm_wdata   = '{present: 1'b1, slot: s_r};
      end
      CMD_DN_RD: begin
        rd_en  = 1'b1;
        addr_a = left[IdxW-1:0];
        addr_b = right[IdxW-1:0];
      end
      CMD_DN_MOVE: begin
        heap_we    = 1'b1;
        heap_wdata = pick;
        pm_we      = 1'b1;
        pm_waddr   = pick.item;
        pm_wdata   = '{present: 1'b1, slot: s_r};
      end
      CMD_PLACE: begin
        heap_we  = 1'b1;
        pm_we    = 1'b1;
        pm_waddr = hold_r.item;
        pm_wdata = '{present: 1'b1, slot: s_r};
      end
      CMD_TOP_RD: rd_en = 1'b1;
      default: ;
    endcase
  end

  // Heap slot memory with two registered read ports.
  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    if (rd_en) begin
      rd_a_q <= heap_mem[addr_a];
      rd_b_q <= heap_mem[addr_b];
    end
  end

  // Position map memory.
  always_ff @(posedge clk) begin
    if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
    if (pm_re) pm_q <= pm_mem[item_r];
  end

  // Count, clearing pointer and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == CMD_CLEAR) clr_addr_r <= clr_addr_r + idx_t'(1);
      if (cmd == CMD_DECIDE) begin
        if (op_r == OP_UPDATE && !pm_q.present) begin
          cnt_r <= cnt_r + cnt_t'(1);
        end else if ((op_r == OP_REMOVE && pm_q.present) ||
                     (op_r == OP_POP && cnt_r != '0)) begin
          cnt_r <= last;
        end
      end
      if (cmd == CMD_RESULT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        op_r     <= op_t'(in_operation);
        item_r   <= in_item_index;
        key_r    <= in_new_key;
        pkey_r   <= '0;
        pidx_r   <= '0;
        status_r <= 1'b0;
      end
      CMD_DECIDE: begin
        if (op_r == OP_UPDATE) begin
          s_r    <= pm_q.present ? pm_q.slot : cnt_r[IdxW-1:0];
          hold_r <= '{item: item_r, key: key_r};
        end else if (op_r == OP_REMOVE) begin
          s_r <= pm_q.slot;
        end else if (op_r == OP_POP && cnt_r == '0) begin
          status_r <= 1'b1;
        end
      end
      CMD_RM: hold_r <= rd_b_q;
      CMD_POP: begin
        pkey_r <= rd_a_q.key;
        pidx_r <= rd_a_q.item;
        hold_r <= rd_b_q;
        s_r    <= '0;
      end
      CMD_UP_MOVE: s_r <= parent;
      CMD_DN_MOVE: s_r <= pick_slot;
      CMD_RESULT: begin
        o_was_r       <= pm_q.present;
        o_pkey_r      <= pkey_r;
        o_pidx_r      <= pidx_r;
        o_top_valid_r <= (cnt_r != '0);
        o_top_key_r   <= (cnt_r != '0) ? rd_a_q.key : '0;
        o_top_idx_r   <= (cnt_r != '0) ? rd_a_q.item : '0;
        o_cnt_r       <= cnt_r;
        o_status_r    <= status_r;
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_was_present  = o_was_r;
  assign out_popped_key   = o_pkey_r;
  assign out_popped_index = o_pidx_r;
  assign out_top_valid    = o_top_valid_r;
  assign out_top_key      = o_top_key_r;
  assign out_top_index    = o_top_idx_r;
  assign out_entry_count  = o_cnt_r;
  assign out_status       = o_status_r;

endmodule

>>> src/indexed_min_heap.sv
// Indexed binary min-heap: one request beat in, one result beat out.
// A request is loaded, looked up and decided; a nop, a failed remove or an empty pop
// then goes straight to the top read and the result, while other requests may sift up
// or down the heap, up to 10 levels, and place the held slot before the top read.
// Requests are taken one at a time; a new one is accepted the cycle after the last
// result is registered, and the sift loop over the heap RAM keeps the block busy until then.
// Reset: synchronous; afterwards a pass clears all 1024 entries of the position map,
// during which in_stall stays high.
module indexed_min_heap
  import imh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  idx_t       in_item_index,
  input  key_t       in_new_key,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_was_present,
  output key_t       out_popped_key,
  output idx_t       out_popped_index,
  output logic       out_top_valid,
  output key_t       out_top_key,
  output idx_t       out_top_index,
  output cnt_t       out_entry_count,
  output logic       out_status
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  imh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Memories and registers.
  imh_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_operation     (in_operation),
    .in_item_index    (in_item_index),
    .in_new_key       (in_new_key),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_was_present  (out_was_present),
    .out_popped_key   (out_popped_key),
    .out_popped_index (out_popped_index),
    .out_top_valid    (out_top_valid),
    .out_top_key      (out_top_key),
    .out_top_index    (out_top_index),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

endmodule

>>> src/imh_checker.sv
// Port-level checks of the indexed min-heap and their binding.
`include "indexed_min_heap_assert.svh"

module imh_checker
  import imh_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_operation,
  input idx_t       in_item_index,
  input key_t       in_new_key,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_was_present,
  input key_t       out_popped_key,
  input idx_t       out_popped_index,
  input logic       out_top_valid,
  input key_t       out_top_key,
  input idx_t       out_top_index,
  input cnt_t       out_entry_count,
  input logic       out_status
);

  // A stalled result beat stays valid.
  `IMH_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped")

  // The top flag agrees with the count.
  `IMH_NEVER(a_top_cnt, out_valid && (out_top_valid != (out_entry_count != '0)), "top vs count")

  // An empty heap shows a zero top.
  `IMH_NEVER(a_empty_top, out_valid && !out_top_valid && (out_top_key != '0 || out_top_index != '0), "empty top nonzero")

  // A rejected pop leaves an empty heap and no popped pair.
  `IMH_NEVER(a_empty_pop, out_valid && out_status && (out_entry_count != '0 || out_popped_key != '0 || out_popped_index != '0), "bad empty pop")

endmodule

bind indexed_min_heap imh_checker u_imh_checker (.*);
